[rtl/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, command and status codes, and default sizes for the pose
// sequence matcher.
// ----------------------------------------------------------------------------
package psm_pkg;

    localparam int MAX_TEMPLATES_DEF = 8;
    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int POSE_W     = 8;
    localparam int ENTRY_W    = POSE_W + 1;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LONG = 2'd2;

    // template memory word: end marker above the pose code
    localparam logic [ENTRY_W-1:0] ENTRY_END = {1'b1, {POSE_W{1'b0}}};

    typedef struct packed {
        logic              push;
        logic              clear;
        logic [POSE_W-1:0] pose;
    } hist_cmd_t;

    typedef struct packed {
        logic load;
        logic step;
    } scan_ctrl_t;

endpackage

[rtl/psm_ram.sv]
// ----------------------------------------------------------------------------
// psm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/psm_hist.sv]
// ----------------------------------------------------------------------------
// psm_hist
// Pose history: packed from slot 0 upward with a fill count; a push into a
// full history drops the oldest pose.
// ----------------------------------------------------------------------------
module psm_hist
    import psm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int CW            = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hist_cmd_t                             cmd,
    output logic [HISTORY_DEPTH-1:0][POSE_W-1:0]  hist,
    output logic [CW-1:0]                         hist_cnt
);

    logic [HISTORY_DEPTH-1:0][POSE_W-1:0] hist_reg;
    logic [CW-1:0]                        cnt_reg;
    logic [CW-1:0]                        cnt_next;
    logic                                 push_ok;
    logic                                 full;

    assign push_ok = cmd.push && (cmd.pose != '0);
    assign full    = (cnt_reg == CW'(HISTORY_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clear)
        begin
            cnt_next = '0;
        end
        else if (push_ok && !full)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            if (full)
            begin
                hist_reg <= {cmd.pose, hist_reg[HISTORY_DEPTH-1:1]};
            end
            else
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    if (CW'(i) == cnt_reg)
                    begin
                        hist_reg[i] <= cmd.pose;
                    end
                end
            end
        end
    end

    assign hist     = hist_reg;
    assign hist_cnt = cnt_reg;

endmodule

[rtl/psm_scan.sv]
// ----------------------------------------------------------------------------
// psm_scan
// Offset lanes for one template: a window of the history shifts by one pose
// per template entry read, and each lane keeps whether its offset still
// agrees. The best offset of the template is the lowest surviving lane.
// ----------------------------------------------------------------------------
module psm_scan
    import psm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int CW            = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scan_ctrl_t                            ctrl,
    input  logic [HISTORY_DEPTH-1:0][POSE_W-1:0]  hist,
    input  logic [CW-1:0]                         hist_cnt,
    input  logic [ENTRY_W-1:0]                    rd_entry,
    output logic                                  hit,
    output logic [CW-1:0]                         hit_level
);

    localparam int IW = $clog2(HISTORY_DEPTH);

    logic [HISTORY_DEPTH-1:0][POSE_W-1:0] win_reg;
    logic [HISTORY_DEPTH-1:0]             vld_reg;
    logic [HISTORY_DEPTH-1:0]             alive_reg;
    logic [HISTORY_DEPTH-1:0]             mask_reg;
    logic [CW-1:0]                        cnt_reg;
    logic [HISTORY_DEPTH-1:0]             mask_next;
    logic [HISTORY_DEPTH-1:0]             alive_next;
    logic [HISTORY_DEPTH-1:0]             cand;
    logic [HISTORY_DEPTH-1:0]             low;
    logic [IW-1:0]                        low_idx;

    always_comb
    begin
        for (int o = 0; o < HISTORY_DEPTH; o++)
        begin
            mask_next[o] = (CW'(o) < hist_cnt);
        end
    end

    always_comb
    begin
        alive_next = alive_reg;
        for (int o = 0; o < HISTORY_DEPTH; o++)
        begin
            if (vld_reg[o] &&
                (rd_entry[ENTRY_W-1] || (rd_entry[POSE_W-1:0] != win_reg[o])))
            begin
                alive_next[o] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            alive_reg <= '0;
            mask_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (ctrl.load)
        begin
            vld_reg   <= mask_next;
            alive_reg <= '1;
            mask_reg  <= mask_next;
            cnt_reg   <= hist_cnt;
        end
        else if (ctrl.step)
        begin
            vld_reg   <= {1'b0, vld_reg[HISTORY_DEPTH-1:1]};
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            win_reg <= hist;
        end
        else if (ctrl.step)
        begin
            win_reg <= {{POSE_W{1'b0}}, win_reg[HISTORY_DEPTH-1:1]};
        end
    end

    assign cand = alive_reg & mask_reg;
    assign low  = cand & (~cand + HISTORY_DEPTH'(1));

    always_comb
    begin
        low_idx = '0;
        for (int o = 0; o < HISTORY_DEPTH; o++)
        begin
            low_idx = low_idx | (low[o] ? IW'(o) : '0);
        end
    end

    assign hit       = |cand;
    assign hit_level = cnt_reg - CW'(low_idx);

endmodule

[rtl/pose_sequence_matcher.sv]
// ----------------------------------------------------------------------------
// pose_sequence_matcher
// Template pose table in a synchronous RAM, a sliding pose history, and a
// sequencer that scores every template at every history offset on query.
// ----------------------------------------------------------------------------
// One beat is processed at a time. Append, push and clear go from the execute
// state to the done state, which registers the result beat once the output is
// free; an append that closes a template shorter than HISTORY_DEPTH first writes
// an end marker. A query reads the template RAM one entry per cycle while all
// offsets are checked in parallel lanes, loading, stepping and evaluating each
// stored template in turn. A new beat is taken while the previous result still
// waits on the output register.
module pose_sequence_matcher
    import psm_pkg::*;
#(
    parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // pose_value[7:0]
    input  logic [1:0]            s_tuser,   // command[1:0]
    input  logic                  s_tlast,   // last_entry
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], match_found[2],
                                             // match_template[5:3],
                                             // match_level[9:6], zero[15:10]
);

    localparam int DEPTH = MAX_TEMPLATES * HISTORY_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int NW    = $clog2(MAX_TEMPLATES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_MARK  = 3'd2;
    localparam logic [2:0] ST_SLOAD = 3'd3;
    localparam logic [2:0] ST_SRUN  = 3'd4;
    localparam logic [2:0] ST_SEVAL = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]            state_reg,     state_next;
    logic [CMD_W-1:0]      cmd_reg,       cmd_next;
    logic [POSE_W-1:0]     pose_reg,      pose_next;
    logic                  last_reg,      last_next;
    logic [NW-1:0]         tcount_reg,    tcount_next;
    logic [CW-1:0]         load_pos_reg,  load_pos_next;
    logic [AW:0]           load_base_reg, load_base_next;
    logic [AW-1:0]         mark_addr_reg, mark_addr_next;
    logic [AW-1:0]         scan_base_reg, scan_base_next;
    logic [CW-1:0]         p_reg,         p_next;
    logic [NW-1:0]         t_idx_reg,     t_idx_next;
    logic [STAT_W-1:0]     status_reg,    status_next;
    logic [CW-1:0]         best_lvl_reg,  best_lvl_next;
    logic [NW-1:0]         best_t_reg,    best_t_next;
    logic                  m_valid_reg,   m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg,    m_data_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    hist_cmd_t                            hist_cmd;
    scan_ctrl_t                           scan_ctrl;
    logic [HISTORY_DEPTH-1:0][POSE_W-1:0] hist;
    logic [CW-1:0]                        hist_cnt;
    logic                                 hit;
    logic [CW-1:0]                        hit_level;

    logic                  in_beat;
    logic                  out_free;
    logic                  full;
    logic [CW-1:0]         pos_new;
    logic [CW+3:0]         lvl_ext;
    logic [NW+2:0]         tpl_ext;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (tcount_reg == NW'(MAX_TEMPLATES));
    assign lvl_ext  = {4'b0000, best_lvl_reg};
    assign tpl_ext  = {3'b000, best_t_reg};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pose_next      = pose_reg;
        last_next      = last_reg;
        tcount_next    = tcount_reg;
        load_pos_next  = load_pos_reg;
        load_base_next = load_base_reg;
        mark_addr_next = mark_addr_reg;
        scan_base_next = scan_base_reg;
        p_next         = p_reg;
        t_idx_next     = t_idx_reg;
        status_next    = status_reg;
        best_lvl_next  = best_lvl_reg;
        best_t_next    = best_t_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_addr       = scan_base_reg + AW'(p_reg);
        ram_wdata      = {1'b0, pose_reg};
        hist_cmd       = '0;
        hist_cmd.pose  = pose_reg;
        scan_ctrl      = '0;
        pos_new        = load_pos_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next   = s_tuser;
                    pose_next  = s_tdata;
                    last_next  = s_tlast;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next   = STAT_OK;
                best_lvl_next = '0;
                best_t_next   = '0;
                state_next    = ST_DONE;
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (load_pos_reg < CW'(HISTORY_DEPTH))
                        begin
                            if (!full)
                            begin
                                ram_we   = 1'b1;
                                ram_addr = AW'(load_base_reg) + AW'(load_pos_reg);
                            end
                            pos_new = load_pos_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = STAT_LONG;
                        end
                        load_pos_next = pos_new;
                        if (last_reg)
                        begin
                            load_pos_next = '0;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                tcount_next    = tcount_reg + 1'b1;
                                load_base_next = load_base_reg + (AW + 1)'(HISTORY_DEPTH);
                                if (pos_new < CW'(HISTORY_DEPTH))
                                begin
                                    mark_addr_next = AW'(load_base_reg) + AW'(pos_new);
                                    state_next     = ST_MARK;
                                end
                            end
                        end
                    end
                    CMD_PUSH:
                    begin
                        hist_cmd.push = 1'b1;
                    end
                    CMD_CLEAR:
                    begin
                        hist_cmd.clear = 1'b1;
                    end
                    CMD_QUERY:
                    begin
                        scan_base_next = '0;
                        p_next         = '0;
                        t_idx_next     = '0;
                        if (tcount_reg != '0)
                        begin
                            state_next = ST_SLOAD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MARK:
            begin
                ram_we     = 1'b1;
                ram_addr   = mark_addr_reg;
                ram_wdata  = ENTRY_END;
                state_next = ST_DONE;
            end
            ST_SLOAD:
            begin
                scan_ctrl.load = 1'b1;
                p_next         = p_reg + 1'b1;
                state_next     = ST_SRUN;
            end
            ST_SRUN:
            begin
                scan_ctrl.step = 1'b1;
                if (p_reg < CW'(HISTORY_DEPTH))
                begin
                    p_next = p_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SEVAL;
                end
            end
            ST_SEVAL:
            begin
                if (hit && (hit_level >= best_lvl_reg))
                begin
                    best_lvl_next = hit_level;
                    best_t_next   = t_idx_reg;
                end
                if ((t_idx_reg + 1'b1) == tcount_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    t_idx_next     = t_idx_reg + 1'b1;
                    scan_base_next = scan_base_reg + AW'(HISTORY_DEPTH);
                    p_next         = '0;
                    state_next     = ST_SLOAD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b000000, lvl_ext[3:0], tpl_ext[2:0],
                                    (best_lvl_reg != '0), status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tcount_reg    <= '0;
            load_pos_reg  <= '0;
            load_base_reg <= '0;
            scan_base_reg <= '0;
            p_reg         <= '0;
            t_idx_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tcount_reg    <= tcount_next;
            load_pos_reg  <= load_pos_next;
            load_base_reg <= load_base_next;
            scan_base_reg <= scan_base_next;
            p_reg         <= p_next;
            t_idx_reg     <= t_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pose_reg      <= pose_next;
        last_reg      <= last_next;
        mark_addr_reg <= mark_addr_next;
        status_reg    <= status_next;
        best_lvl_reg  <= best_lvl_next;
        best_t_reg    <= best_t_next;
        m_data_reg    <= m_data_next;
    end

    psm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_tmpl_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    psm_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CW            (CW)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (hist_cmd),
        .hist     (hist),
        .hist_cnt (hist_cnt)
    );

    psm_scan #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CW            (CW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .hist      (hist),
        .hist_cnt  (hist_cnt),
        .rd_entry  (ram_rdata),
        .hit       (hit),
        .hit_level (hit_level)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_tcount_max: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= NW'(MAX_TEMPLATES))
        else $error("template count beyond table size");

    a_load_pos_max: assert property (@(posedge clk) disable iff (!rst_n)
        load_pos_reg <= CW'(HISTORY_DEPTH))
        else $error("load position beyond history depth");

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC || state_reg == ST_MARK))
        else $error("template memory written outside append");

    a_beat_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEVAL) |-> (t_idx_reg < tcount_reg))
        else $error("scan past stored templates");
`endif

endmodule
